// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ctcgd_pkg.sv =====
`timescale 1ns / 1ps

package ctcgd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int NCLS_W      = 8;
    localparam int SEQ_W       = 9;
    localparam int IDX_W       = 7;
    localparam int OSCORE_W    = 16;
    localparam int KEPT_W      = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_CLASSES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQ_LEN     = 2'd1;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [NCLS_W-1:0] NUM_CLASSES_RST = 8'd97;
    localparam logic [SEQ_W-1:0]  SEQ_LEN_RST     = 9'd40;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // score transfer this cycle
        logic load_char;  // load a character result into the output register
        logic load_sum;   // load the summary result into the output register
        logic start_div;  // start the mean-score division
        logic clear_seq;  // clear all sequence state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic keep;       // current score ends a row whose winner is kept
        logic last_row;   // current score ends the last row of the sequence
        logic div_busy;
    } t_status;

endpackage

// ===== hw/rtl/ctcgd_div.sv =====
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
module ctcgd_div #(
    parameter int DW = 25,
    parameter int VW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [VW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_quo, n_quo;
    logic [VW-1:0]   r_dvs, n_dvs;
    logic [VW:0]     rem_shift;
    logic [VW:0]     rem_diff;
    logic            fits;

    assign rem_shift = {r_rem, r_quo[DW-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvs};
    assign fits      = rem_shift >= {1'b0, r_dvs};

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dvs = r_dvs;
        if (i_start) begin
            n_cnt = CNTW'(DW);
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNTW'(1);
            n_rem = fits ? rem_diff[VW-1:0] : rem_shift[VW-1:0];
            n_quo = {r_quo[DW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/ctcgd_datapath.sv =====
`timescale 1ns / 1ps

module ctcgd_datapath #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 256,
    parameter int SCORE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ctcgd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ctcgd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [SCORE_BITS-1:0]        i_score,
    input  ctcgd_pkg::t_cmd                     i_cmd,
    output ctcgd_pkg::t_status                  o_status,
    output logic                                o_kind,
    output logic [ctcgd_pkg::IDX_W-1:0]         o_char_index,
    output logic signed [ctcgd_pkg::OSCORE_W-1:0] o_char_score,
    output logic signed [ctcgd_pkg::OSCORE_W-1:0] o_confidence,
    output logic [ctcgd_pkg::KEPT_W-1:0]        o_kept_count,
    output logic                                o_last
);

    localparam int CLW   = $clog2(MAX_CLASSES);
    localparam int ECW   = $clog2(MAX_CLASSES + 1);
    localparam int CMPW  = (ECW > ctcgd_pkg::NCLS_W) ? ECW : ctcgd_pkg::NCLS_W;
    localparam int STW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int STCW  = $clog2(MAX_STEPS + 1);
    localparam int SCMPW = (STCW > ctcgd_pkg::SEQ_W) ? STCW : ctcgd_pkg::SEQ_W;
    localparam int KW    = $clog2(MAX_STEPS + 1);
    localparam int SUMW  = SCORE_BITS + KW;

    localparam logic [CMPW-1:0]  MAX_CLS_C  = CMPW'(MAX_CLASSES);
    localparam logic [SCMPW-1:0] MAX_STEP_C = SCMPW'(MAX_STEPS);

    logic [ctcgd_pkg::NCLS_W-1:0] r_num_classes;
    logic [ctcgd_pkg::SEQ_W-1:0]  r_seq_len;

    logic [CLW-1:0]               r_class_cnt;
    logic [STW-1:0]               r_step_cnt;
    logic signed [SCORE_BITS-1:0] r_best_score;
    logic [CLW-1:0]               r_best_class;
    logic [CLW-1:0]               r_prev_class;
    logic                         r_prev_valid;
    logic signed [SUMW-1:0]       r_sum;
    logic [KW-1:0]                r_kept;

    logic                               r_kind;
    logic [ctcgd_pkg::IDX_W-1:0]        r_char_index;
    logic signed [ctcgd_pkg::OSCORE_W-1:0] r_char_score;
    logic signed [ctcgd_pkg::OSCORE_W-1:0] r_conf;
    logic [ctcgd_pkg::KEPT_W-1:0]       r_kept_count;
    logic                               r_last;

    logic [CMPW-1:0]              cfg_cls;
    logic [CMPW-1:0]              eff_cls;
    logic [SCMPW-1:0]             cfg_steps;
    logic [SCMPW-1:0]             eff_steps;
    logic                         row_end;
    logic                         last_step;
    logic                         take;
    logic signed [SCORE_BITS-1:0] cur_score;
    logic [CLW-1:0]               cur_class;
    logic                         keep;
    logic [KW-1:0]                kept_inc;
    logic                         cfg_clear;
    logic [SUMW-1:0]              sum_mag;
    logic [SUMW-1:0]              quo;
    logic signed [SUMW-1:0]       mean;
    logic                         div_busy;

    assign cfg_cls   = CMPW'(r_num_classes);
    assign eff_cls   = (cfg_cls < CMPW'(2)) ? CMPW'(2) :
                       (cfg_cls > MAX_CLS_C) ? MAX_CLS_C : cfg_cls;
    assign cfg_steps = SCMPW'(r_seq_len);
    assign eff_steps = (cfg_steps == '0) ? SCMPW'(1) :
                       (cfg_steps > MAX_STEP_C) ? MAX_STEP_C : cfg_steps;

    assign row_end   = (CMPW'(r_class_cnt) + CMPW'(1)) >= eff_cls;
    assign last_step = (SCMPW'(r_step_cnt) + SCMPW'(1)) >= eff_steps;

    // first class of a row always wins; ties keep the lower index
    assign take      = (r_class_cnt == '0) || (i_score > r_best_score);
    assign cur_score = take ? i_score : r_best_score;
    assign cur_class = take ? r_class_cnt : r_best_class;
    assign keep      = row_end && (cur_class != '0) &&
                       !(r_prev_valid && (r_prev_class == cur_class));
    assign kept_inc  = r_kept + KW'(1);

    assign cfg_clear = i_cfg_we && ((i_cfg_index == ctcgd_pkg::REG_NUM_CLASSES) ||
                                    (i_cfg_index == ctcgd_pkg::REG_SEQ_LEN));

    assign o_status.keep     = keep;
    assign o_status.last_row = row_end && last_step;
    assign o_status.div_busy = div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= ctcgd_pkg::NUM_CLASSES_RST;
            r_seq_len     <= ctcgd_pkg::SEQ_LEN_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ctcgd_pkg::REG_NUM_CLASSES) begin
                r_num_classes <= i_cfg_data[ctcgd_pkg::NCLS_W-1:0];
            end else if (i_cfg_index == ctcgd_pkg::REG_SEQ_LEN) begin
                r_seq_len <= i_cfg_data[ctcgd_pkg::SEQ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear || i_cmd.clear_seq) begin
            r_class_cnt  <= '0;
            r_step_cnt   <= '0;
            r_best_score <= '0;
            r_best_class <= '0;
            r_prev_class <= '0;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
            r_kept       <= '0;
        end else if (i_cmd.accept) begin
            r_best_score <= cur_score;
            r_best_class <= cur_class;
            if (row_end) begin
                r_class_cnt  <= '0;
                r_prev_class <= cur_class;
                r_prev_valid <= 1'b1;
                if (keep) begin
                    r_sum  <= r_sum + SUMW'(cur_score);
                    r_kept <= kept_inc;
                end
                r_step_cnt <= last_step ? '0 : r_step_cnt + STW'(1);
            end else begin
                r_class_cnt <= r_class_cnt + CLW'(1);
            end
        end
    end

    // mean = sum / kept, truncated toward zero: divide magnitudes, restore sign
    assign sum_mag = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign mean    = r_sum[SUMW-1] ? -$signed(quo) : $signed(quo);

    ctcgd_div #(
        .DW (SUMW),
        .VW (KW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (sum_mag),
        .i_divisor  (r_kept),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_kind       <= ctcgd_pkg::KIND_CHAR;
            r_char_index <= ctcgd_pkg::IDX_W'(cur_class - CLW'(1));
            r_char_score <= ctcgd_pkg::OSCORE_W'(cur_score);
            r_conf       <= '0;
            r_kept_count <= ctcgd_pkg::KEPT_W'(kept_inc);
            r_last       <= 1'b0;
        end else if (i_cmd.load_sum) begin
            r_kind       <= ctcgd_pkg::KIND_SUMMARY;
            r_char_index <= '0;
            r_char_score <= '0;
            r_conf       <= (r_kept == '0) ? '0 : ctcgd_pkg::OSCORE_W'(mean);
            r_kept_count <= ctcgd_pkg::KEPT_W'(r_kept);
            r_last       <= 1'b1;
        end
    end

    assign o_kind       = r_kind;
    assign o_char_index = r_char_index;
    assign o_char_score = r_char_score;
    assign o_confidence = r_conf;
    assign o_kept_count = r_kept_count;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/ctcgd_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctcgd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  ctcgd_pkg::t_status i_status,
    output ctcgd_pkg::t_cmd    o_cmd,
    output logic               o_stall,
    output logic               o_valid
);

    localparam logic [1:0] S_RUN       = 2'd0;
    localparam logic [1:0] S_DIV_START = 2'd1;
    localparam logic [1:0] S_DIV_WAIT  = 2'd2;
    localparam logic [1:0] S_SUM       = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       load;

    // output register can take new data this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_RUN: begin
                if (i_valid && out_free) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.load_char = i_status.keep;
                    if (i_status.last_row) begin
                        n_state = S_DIV_START;
                    end
                end
            end
            S_DIV_START: begin
                o_cmd.start_div = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    o_cmd.load_sum  = 1'b1;
                    o_cmd.clear_seq = 1'b1;
                    n_state         = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    assign load        = o_cmd.load_char || o_cmd.load_sum;
    assign n_out_valid = load ? 1'b1 : (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = !((r_state == S_RUN) && out_free);
    assign o_valid = r_out_valid;

    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, load, !r_out_valid || !i_stall, "result overwritten before transfer")
    `ASSERT_ALWAYS(a_one_load, i_clk, i_rst_n, !(o_cmd.load_char && o_cmd.load_sum), "two results loaded at once")
    `ASSERT_NEXT(a_div_starts, i_clk, i_rst_n, r_state == S_DIV_START, i_status.div_busy, "divider did not start")
    `ASSERT_NEXT(a_last_row, i_clk, i_rst_n, o_cmd.accept && i_status.last_row, r_state == S_DIV_START, "sequence end missed")

endmodule

// ===== hw/rtl/ctc_greedy_decoder.sv =====
`timescale 1ns / 1ps

// CTC greedy (best path) decoder. Scores stream in one per cycle while o_stall
// is low, class by class within a row of num_classes, rows in time order. At
// each row end the argmax (lower index on a tie) is kept unless it is blank or
// repeats the previous row's winner, and a kept winner is sent out as a
// character result. A row end with a kept character is accepted like any
// other score as long as the output register is free or being drained. After
// the last row the mean kept score is computed by a restoring divider producing
// one quotient bit per cycle; the summary is loaded in S_SUM after S_DIV_START
// and S_DIV_WAIT, and no score is taken before then. Writes to the num_classes
// or seq_len register restart the current sequence.
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 256,
    parameter int SCORE_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ctcgd_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [ctcgd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [SCORE_BITS-1:0]           i_score,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_kind,
    output logic [ctcgd_pkg::IDX_W-1:0]            o_char_index,
    output logic signed [ctcgd_pkg::OSCORE_W-1:0]  o_char_score,
    output logic signed [ctcgd_pkg::OSCORE_W-1:0]  o_confidence,
    output logic [ctcgd_pkg::KEPT_W-1:0]           o_kept_count,
    output logic                                   o_last
);

    ctcgd_pkg::t_cmd    cmd;
    ctcgd_pkg::t_status status;

    ctcgd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    ctcgd_datapath #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS),
        .SCORE_BITS  (SCORE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_score      (i_score),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_kind       (o_kind),
        .o_char_index (o_char_index),
        .o_char_score (o_char_score),
        .o_confidence (o_confidence),
        .o_kept_count (o_kept_count),
        .o_last       (o_last)
    );

endmodule

// ===== sim/ctc_greedy_decoder_tb.sv =====
`timescale 1ns / 1ps

module ctc_greedy_decoder_tb;

    localparam int MAX_CLS      = 128;
    localparam int MAX_ROWS     = 256;
    localparam int DRAIN_GAP    = 40;   // covers the divide plus margin
    localparam int RANDOM_ITEMS = 300;

    // indexes the block does not decode
    localparam logic [ctcgd_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [ctcgd_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic                                  kind;
        logic [ctcgd_pkg::IDX_W-1:0]           char_index;
        logic signed [ctcgd_pkg::OSCORE_W-1:0] char_score;
        logic signed [ctcgd_pkg::OSCORE_W-1:0] confidence;
        logic [ctcgd_pkg::KEPT_W-1:0]          kept_count;
        logic                                  last;
    } t_decode;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_we = 1'b0;
    logic [ctcgd_pkg::CFG_INDEX_W-1:0]     i_cfg_index = '0;
    logic [ctcgd_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                  i_valid = 1'b0;
    logic                                  o_stall;
    logic signed [15:0]                    i_score = '0;
    logic                                  o_valid;
    logic                                  i_stall = 1'b0;
    logic                                  o_kind;
    logic [ctcgd_pkg::IDX_W-1:0]           o_char_index;
    logic signed [ctcgd_pkg::OSCORE_W-1:0] o_char_score;
    logic signed [ctcgd_pkg::OSCORE_W-1:0] o_confidence;
    logic [ctcgd_pkg::KEPT_W-1:0]          o_kept_count;
    logic                                  o_last;

    ctc_greedy_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_score      (i_score),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_char_index (o_char_index),
        .o_char_score (o_char_score),
        .o_confidence (o_confidence),
        .o_kept_count (o_kept_count),
        .o_last       (o_last)
    );

    logic signed [15:0] score_q[$];
    t_decode            decode_q[$];
    int                 fail_count = 0;
    int                 src_idle = 21;
    int                 snk_idle = 57;

    // decoder model state
    logic [7:0]         ncls_reg = ctcgd_pkg::NUM_CLASSES_RST;
    logic [8:0]         slen_reg = ctcgd_pkg::SEQ_LEN_RST;
    int                 row_pos = 0;
    int                 row_idx = 0;
    logic signed [15:0] top_score = '0;
    int                 top_class = 0;
    int                 last_class = 0;
    logic               last_seen = 1'b0;
    longint             kept_sum = 0;
    int                 kept_n = 0;

    task automatic queue_score(input logic signed [15:0] v);
        score_q = {score_q, v};
    endtask

    task automatic queue_result(input t_decode v);
        decode_q = {decode_q, v};
    endtask

    function automatic int row_width();
        int c = int'(ncls_reg);
        if (c < 2) c = 2;
        if (c > MAX_CLS) c = MAX_CLS;
        return c;
    endfunction

    function automatic int seq_rows();
        int s = int'(slen_reg);
        if (s < 1) s = 1;
        if (s > MAX_ROWS) s = MAX_ROWS;
        return s;
    endfunction

    task automatic restart_sequence();
        row_pos = 0;
        row_idx = 0;
        top_score = '0;
        top_class = 0;
        last_class = 0;
        last_seen = 1'b0;
        kept_sum = 0;
        kept_n = 0;
    endtask

    task automatic greedy_take_score(input logic signed [15:0] s);
        t_decode r;
        longint  mean;
        if (row_pos == 0 || s > top_score) begin
            top_score = s;
            top_class = row_pos;
        end
        if (row_pos + 1 < row_width()) begin
            row_pos++;
            return;
        end
        row_pos = 0;
        // blank and repeats of the previous winner are dropped
        if (top_class != 0 && !(last_seen && last_class == top_class)) begin
            kept_sum += longint'(top_score);
            kept_n++;
            r.kind       = ctcgd_pkg::KIND_CHAR;
            r.char_index = ctcgd_pkg::IDX_W'(top_class - 1);
            r.char_score = top_score;
            r.confidence = '0;
            r.kept_count = ctcgd_pkg::KEPT_W'(kept_n);
            r.last       = 1'b0;
            queue_result(r);
        end
        last_class = top_class;
        last_seen = 1'b1;
        if (row_idx + 1 < seq_rows()) begin
            row_idx++;
            return;
        end
        mean = (kept_n > 0) ? kept_sum / longint'(kept_n) : longint'(0);
        r.kind       = ctcgd_pkg::KIND_SUMMARY;
        r.char_index = '0;
        r.char_score = '0;
        r.confidence = ctcgd_pkg::OSCORE_W'(mean);
        r.kept_count = ctcgd_pkg::KEPT_W'(kept_n);
        r.last       = 1'b1;
        queue_result(r);
        restart_sequence();
    endtask

    task automatic check_field(input string fld, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %0d got %0d", $time, fld, want, got);
        end
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("ctc_greedy_decoder: mismatch");
        $finish;
    end

    // score sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) greedy_take_score(i_score);
            if (!i_valid || !o_stall) begin
                if (score_q.size() != 0 && $urandom_range(99) >= src_idle) begin
                    i_score <= score_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < snk_idle);
    end

    // result checker
    always @(posedge i_clk) begin : result_mon
        t_decode want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decode_q.size() == 0) begin
                fail_count++;
                $display("%0t: expected no transfer, got kind %0d index %0d kept %0d",
                         $time, o_kind, o_char_index, o_kept_count);
            end else begin
                want = decode_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("char_index", 32'(want.char_index), 32'(o_char_index));
                check_field("char_score", 32'(want.char_score), 32'(o_char_score));
                check_field("confidence", 32'(want.confidence), 32'(o_confidence));
                check_field("kept_count", 32'(want.kept_count), 32'(o_kept_count));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    task automatic cfg_write(input logic [ctcgd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [8:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            ctcgd_pkg::REG_NUM_CLASSES: begin
                ncls_reg = data[7:0];
                restart_sequence();
            end
            ctcgd_pkg::REG_SEQ_LEN: begin
                slen_reg = data;
                restart_sequence();
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender holds off until every result is in, then the block gets time to settle;
    // sampled at the falling edge so the sender's updates have landed
    task automatic wait_drained();
        do @(negedge i_clk);
        while (score_q.size() != 0 || i_valid || decode_q.size() != 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic push_row(input int width, input int win, input int top, input int lo);
        for (int c = 0; c < width; c++) queue_score(16'((c == win) ? top : lo));
    endtask

    task automatic push_rand_row(input int width, inout int prev_win);
        int win;
        int top;
        int mode;
        mode = $urandom_range(3);
        case ($urandom_range(3))
            0: win = prev_win;
            1: win = 0;
            default: win = $urandom_range(width - 1);
        endcase
        if (win >= width) win = width - 1;
        case ($urandom_range(7))
            0: top = 32767;
            1: top = -32768;
            2: top = -32767;
            default: top = $urandom_range(65535) - 32768;
        endcase
        for (int c = 0; c < width; c++) begin
            if (mode == 0) queue_score(16'($urandom));
            else if (c == win) queue_score(16'(top));
            else if (top == -32768 || $urandom_range(5) == 0) queue_score(16'(top));
            else queue_score(16'(top - 1 - $urandom_range(top + 32767)));
        end
        prev_win = win;
    endtask

    initial begin
        int   width;
        int   rows;
        int   n;
        int   prev;
        int   cls;
        int   steps;
        int   rnd_items;
        logic broken;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // out-of-range sizes clamp to two classes and one row
        cfg_write(ctcgd_pkg::REG_NUM_CLASSES, 9'd1);
        cfg_write(ctcgd_pkg::REG_SEQ_LEN, 9'd0);
        push_row(2, 1, 32767, -32768);
        push_row(2, 0, 5, 5);               // tie goes to blank
        wait_drained();

        cfg_write(ctcgd_pkg::REG_NUM_CLASSES, 9'd3);
        cfg_write(ctcgd_pkg::REG_SEQ_LEN, 9'd3);
        push_row(3, 2, 100, -7);
        push_row(3, 2, 200, 0);             // repeat dropped
        push_row(3, 0, 50, -50);
        push_row(3, 1, -3, -9);
        wait_drained();
        cfg_write(REG_SPARE_2, 9'h1ff);     // ignored, sequence carries on
        push_row(3, 0, 0, -1);              // blank splits the repeat
        push_row(3, 1, -2, -32768);         // mean -5/2 truncates to -2

        rnd_items = 0;
        broken = 1'b1;
        while (rnd_items < RANDOM_ITEMS) begin
            if (broken || $urandom_range(2) == 0) begin
                wait_drained();
                if (rnd_items < RANDOM_ITEMS / 3) begin
                    src_idle = 21;
                    snk_idle = 57;
                end else if (rnd_items < 2 * RANDOM_ITEMS / 3) begin
                    src_idle = 57;
                    snk_idle = 21;
                end else begin
                    src_idle = 0;
                    snk_idle = 0;
                end
                case ($urandom_range(19))
                    0: cls = $urandom_range(1);
                    1: cls = 128 + $urandom_range(127);
                    2, 3, 4: cls = $urandom_range(20, 7);
                    default: cls = $urandom_range(6, 2);
                endcase
                case ($urandom_range(9))
                    0: steps = 0;
                    1, 2, 3: steps = $urandom_range(16, 7);
                    default: steps = $urandom_range(6, 1);
                endcase
                if (cls > 20) steps = $urandom_range(1);
                if ($urandom_range(3) == 0 && !broken) begin
                    if ($urandom_range(1)) cfg_write(ctcgd_pkg::REG_NUM_CLASSES, 9'(cls));
                    else cfg_write(ctcgd_pkg::REG_SEQ_LEN, 9'(steps));
                end else if ($urandom_range(1)) begin
                    cfg_write(ctcgd_pkg::REG_NUM_CLASSES, 9'(cls));
                    cfg_write(ctcgd_pkg::REG_SEQ_LEN, 9'(steps));
                end else begin
                    cfg_write(ctcgd_pkg::REG_SEQ_LEN, 9'(steps));
                    cfg_write(ctcgd_pkg::REG_NUM_CLASSES, 9'(cls));
                end
                if ($urandom_range(3) == 0) begin
                    cfg_write($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 9'($urandom));
                end
                broken = 1'b0;
            end else if ($urandom_range(7) == 0) begin
                wait_drained();
            end
            width = row_width();
            rows = seq_rows();
            prev = 0;
            if ($urandom_range(9) == 0) begin
                // cut a sequence short; the next write restarts it
                n = $urandom_range(width * rows - 1);
                for (int k = 0; k < n; k++) queue_score(16'($urandom));
                rnd_items += n;
                broken = 1'b1;
            end else begin
                for (int r = 0; r < rows; r++) push_rand_row(width, prev);
                rnd_items += width * rows;
            end
        end

        // widest row
        wait_drained();
        src_idle = 0;
        snk_idle = 0;
        cfg_write(ctcgd_pkg::REG_NUM_CLASSES, 9'h1ff);
        cfg_write(ctcgd_pkg::REG_SEQ_LEN, 9'd1);
        push_row(MAX_CLS, MAX_CLS - 1, 32767, -32768);

        wait_drained();
        if (fail_count == 0 && decode_q.size() == 0) begin
            $display("ctc_greedy_decoder: match");
        end else begin
            $display("ctc_greedy_decoder: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ctcgd_pkg.sv
hw/rtl/ctcgd_div.sv
hw/rtl/ctcgd_datapath.sv
hw/rtl/ctcgd_ctrl.sv
hw/rtl/ctc_greedy_decoder.sv
sim/ctc_greedy_decoder_tb.sv
